// ----- hw/rtl/bscf_pkg.sv -----
// Shared constants for the bond set canonical form block.
package bscf_pkg;
  localparam int unsigned NUM_SYM = 8;
  localparam int unsigned SYM_BITS = 3;
  localparam int unsigned SWAP_SYM = 4;
endpackage

// ----- hw/rtl/bscf_if.sv -----
// Valid/ready stream interfaces for bond input and canonical result channels.
interface bscf_in_if #(parameter int COORD_BITS = 6) (input logic clk);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] bond_x;
  logic [COORD_BITS-1:0] bond_y;
  logic                  bond_dir;
  logic                  last_bond;
  modport source (output valid, bond_x, bond_y, bond_dir, last_bond, input ready);
  modport sink (input valid, bond_x, bond_y, bond_dir, last_bond, output ready);
endinterface

interface bscf_out_if #(parameter int COORD_BITS = 6) (input logic clk);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_dir;
  logic                  out_last;
  modport source (output valid, out_x, out_y, out_dir, out_last, input ready);
  modport sink (input valid, out_x, out_y, out_dir, out_last, output ready);
endinterface

// ----- hw/rtl/bond_set_canonical_form_core.sv -----
// Bond set canonical form: loads a bond set and emits its lowest D4 image.
//
// Bonds arrive one transfer per cycle while the block is loading. A
// last_bond item starts the search: for each of the eight symmetries one
// pass transforms the bonds and finds the minimum x and y, then an
// insertion sort builds the image one key per step using a single shared
// compare (a fetch step, one shift step per shifted key and an insert step
// per key), then for every symmetry but the first a compare pass checks it
// against the best image and a copy pass keeps it when lower; the first
// image is always copied. The set then streams out one bond per accepted
// output transfer. The sort, done by the one shared comparator over the
// candidate store, sets most of the run time. Bonds beyond MAX_BONDS are
// dropped; a last_bond on a dropped bond still starts the search.
module bond_set_canonical_form_core #(
  parameter int MAX_BONDS  = 24,
  parameter int COORD_BITS = 6
) (
  input  logic clk,
  input  logic rst_n,
  bscf_in_if.sink    in_ch,
  bscf_out_if.source out_ch
);
  import bscf_pkg::*;

  localparam int IDX_BITS = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int CNT_BITS = $clog2(MAX_BONDS + 1);
  localparam int FW       = COORD_BITS + 2;       // translated field width
  localparam int KEY_W    = 2 * FW + 1;
  localparam int SW       = COORD_BITS + 2;       // signed image coordinate

  typedef enum logic [2:0] {
    ST_LOAD, ST_XFORM, ST_SORT, ST_CMP, ST_COPY, ST_EMIT
  } state_t;

  state_t                 state_r;
  logic [CNT_BITS-1:0]    count_r;
  logic [SYM_BITS-1:0]    sym_r;
  logic [CNT_BITS-1:0]    i_r;        // outer index
  logic [CNT_BITS-1:0]    j_r;        // insertion slot
  logic [KEY_W-1:0]       key_r;      // key being inserted
  logic signed [SW-1:0]   minx_r, miny_r;
  logic                   done_cmp_r;

  logic [2*COORD_BITS:0]  in_mem   [MAX_BONDS];
  logic [KEY_W-1:0]       cand_mem [MAX_BONDS];
  logic [KEY_W-1:0]       best_mem [MAX_BONDS];
  logic signed [SW-1:0]   imx_mem  [MAX_BONDS];
  logic signed [SW-1:0]   imy_mem  [MAX_BONDS];
  logic                   imd_mem  [MAX_BONDS];

  // shared symmetry unit on the bond at i_r
  logic [2*COORD_BITS:0]  cur_bond;
  logic signed [SW-1:0]   px, py, rx, ry;
  logic                   nd;
  logic [IDX_BITS-1:0]    ii, jj, jm1;
  logic [KEY_W-1:0]       new_key, prev_key;
  logic [FW-1:0]          tx, ty;
  logic signed [SW-1:0]   ex, ey;

  assign ii  = i_r[IDX_BITS-1:0];
  assign jj  = j_r[IDX_BITS-1:0];
  assign jm1 = IDX_BITS'(j_r - 1'b1);
  assign cur_bond = in_mem[ii];

  always_comb begin
    nd = cur_bond[0] ^ (sym_r >= SYM_BITS'(SWAP_SYM));
    px = (sym_r >= SYM_BITS'(SWAP_SYM)) ? SW'(cur_bond[2*COORD_BITS:COORD_BITS+1])
                                        : SW'(cur_bond[COORD_BITS:1]);
    py = (sym_r >= SYM_BITS'(SWAP_SYM)) ? SW'(cur_bond[COORD_BITS:1])
                                        : SW'(cur_bond[2*COORD_BITS:COORD_BITS+1]);
    rx = sym_r[0] ? (-px - SW'(!nd)) : px;
    ry = sym_r[1] ? (-py - SW'(nd))  : py;
    ex = imx_mem[ii] - minx_r;
    ey = imy_mem[ii] - miny_r;
    tx = ex[FW-1:0];
    ty = ey[FW-1:0];
    new_key  = {ty, tx, imd_mem[ii]};
    prev_key = cand_mem[jm1];
  end

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = (state_r == ST_EMIT);
  assign out_ch.out_x    = best_mem[ii][COORD_BITS:1];
  assign out_ch.out_y    = best_mem[ii][FW+COORD_BITS:FW+1];
  assign out_ch.out_dir  = best_mem[ii][0];
  assign out_ch.out_last = (i_r + 1'b1 == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      sym_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_ch.valid) begin
            if (count_r < CNT_BITS'(MAX_BONDS)) begin
              in_mem[count_r[IDX_BITS-1:0]] <= {in_ch.bond_y, in_ch.bond_x, in_ch.bond_dir};
              count_r <= count_r + 1'b1;
            end
            if (in_ch.last_bond) begin
              state_r <= ST_XFORM;
              sym_r   <= '0;
              i_r     <= '0;
            end
          end
        end
        ST_XFORM: begin
          // transform bond i and track minimum
          imx_mem[ii] <= rx;
          imy_mem[ii] <= ry;
          imd_mem[ii] <= nd;
          if (i_r == '0 || rx < minx_r) minx_r <= rx;
          if (i_r == '0 || ry < miny_r) miny_r <= ry;
          if (i_r + 1'b1 >= count_r) begin
            state_r <= ST_SORT;
            i_r     <= '0;
            j_r     <= '0;
            key_r   <= '0;
            done_cmp_r <= 1'b1;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_SORT: begin
          // done_cmp_r: fetch new key at slot i; else shift or insert step
          if (done_cmp_r) begin
            key_r <= new_key;
            j_r   <= i_r;
            done_cmp_r <= 1'b0;
          end else if (j_r != '0 && prev_key > key_r) begin
            cand_mem[jj] <= prev_key;
            j_r <= j_r - 1'b1;
          end else begin
            cand_mem[jj] <= key_r;
            done_cmp_r <= 1'b1;
            if (i_r + 1'b1 >= count_r) begin
              i_r     <= '0;
              state_r <= (sym_r == '0) ? ST_COPY : ST_CMP;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        ST_CMP: begin
          if (cand_mem[ii] != best_mem[ii]) begin
            i_r <= '0;
            if (cand_mem[ii] < best_mem[ii]) begin
              state_r <= ST_COPY;
            end else begin
              sym_r   <= sym_r + 1'b1;
              state_r <= (sym_r == SYM_BITS'(NUM_SYM - 1)) ? ST_EMIT : ST_XFORM;
            end
          end else if (i_r + 1'b1 >= count_r) begin
            i_r   <= '0;
            sym_r <= sym_r + 1'b1;
            state_r <= (sym_r == SYM_BITS'(NUM_SYM - 1)) ? ST_EMIT : ST_XFORM;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_COPY: begin
          best_mem[ii] <= cand_mem[ii];
          if (i_r + 1'b1 >= count_r) begin
            i_r   <= '0;
            sym_r <= sym_r + 1'b1;
            state_r <= (sym_r == SYM_BITS'(NUM_SYM - 1)) ? ST_EMIT : ST_XFORM;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            if (i_r + 1'b1 == count_r) begin
              state_r <= ST_LOAD;
              count_r <= '0;
              i_r     <= '0;
              sym_r   <= '0;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end
endmodule
